### src/fpfir_pkg.sv
// fpfir_pkg: shared types and constants of the fixed-point fir filter
// used by fpfir_cell, fixed_point_fir_filter_top and the verif modules; depends on nothing
`default_nettype none

package fpfir_pkg;

   localparam int SampleW = 16;
   localparam int AccW    = 32;
   localparam int IdxW    = 6;
   localparam int KindW   = 2;
   localparam int TapCntW = 7;
   localparam int ShiftW  = 5;

   localparam logic [KindW-1:0] KIND_SAMPLE   = 2'd0;
   localparam logic [KindW-1:0] KIND_WR_COEF  = 2'd1;
   localparam logic [KindW-1:0] KIND_WR_DELAY = 2'd2;
   localparam logic [KindW-1:0] KIND_RD_DELAY = 2'd3;

   // csr register select, taken from paddr bit 2
   localparam logic REG_TAP_COUNT = 1'b0;
   localparam logic REG_ACC_SHIFT = 1'b1;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic                      shift;     // sample transfer: move delay line
      logic                      wr_coef;
      logic                      wr_delay;
      logic                      readback;  // chain selects a delay element
      logic [IdxW-1:0]           idx;
      logic signed [SampleW-1:0] value;
      logic [TapCntW-1:0]        tap_count;
   } cell_ctl_type;

endpackage

`default_nettype wire

### src/fpfir_cell.sv
// fpfir_cell: one tap of the filter, holding a coefficient and a delay element
// and forming the running sum handed on to the next cell; uses fpfir_pkg
`default_nettype none

module fpfir_cell
   import fpfir_pkg::*;
#(
   parameter int IDX = 0
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire cell_ctl_type         ctl,
   input  wire signed [SampleW-1:0]  delay_left,
   input  wire signed [AccW-1:0]     sum_left,
   output logic signed [SampleW-1:0] delay_out,
   output logic signed [AccW-1:0]    sum_out
);

   logic signed [SampleW-1:0] coef_ff, coef_in;
   logic signed [SampleW-1:0] delay_ff, delay_in;
   logic signed [AccW-1:0]    sum_ff, sum_in;
   logic signed [AccW-1:0]    prod;
   logic                      active;
   logic                      match;

   // tap zero is always in use; cells past the tap count only pass the sum on
   assign active = (IDX == 0) || (32'(IDX) < {25'b0, ctl.tap_count});
   assign match  = ({26'b0, ctl.idx} == 32'(IDX));
   assign prod   = coef_ff * delay_ff;

   always_comb begin
      coef_in  = coef_ff;
      delay_in = delay_ff;
      if (ctl.wr_coef && match) begin
         coef_in = ctl.value;
      end
      if (ctl.shift && active) begin
         delay_in = delay_left;
      end else if (ctl.wr_delay && match) begin
         delay_in = ctl.value;
      end
      if (ctl.readback) begin
         sum_in = match ? AccW'(delay_ff) : sum_left;
      end else begin
         sum_in = active ? sum_left + prod : sum_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff  <= '0;
         delay_ff <= '0;
      end else begin
         coef_ff  <= coef_in;
         delay_ff <= delay_in;
      end
      sum_ff <= sum_in;
   end

   assign delay_out = delay_ff;
   assign sum_out   = sum_ff;

endmodule

`default_nettype wire

### src/fixed_point_fir_filter_top.sv
// fixed_point_fir_filter_top: direct-form fir filter built as a chain of tap cells
// with stream ports and an apb-style csr port; uses fpfir_pkg and fpfir_cell
`default_nettype none

// channel   dir  ports            contents
// req       in   req_t*           tuser kind, tdata tap_index and value
// rsp       out  rsp_t*           tuser is_readback, tdata result
// csr       in   csr_p*           tap_count at 0x0, acc_shift at 0x4
//
// a sample or read-back result ripples through the cells' sums, one cell a cycle, then is
// rounded and shifted (skipped by a read-back) into the output register; the next item is
// taken no earlier than the cycle in which that result turns valid. coefficient and delay
// writes give no result and do not make the block busy. a waiting result does not block
// acceptance of the next item but holds that item's result in the chain until rsp_tready.
// reset clears the whole coefficient and delay store at once.

module fixed_point_fir_filter_top
   import fpfir_pkg::*;
#(
   parameter int MAX_TAPS = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // [5:0] tap_index, [21:6] value, [23:22] zero
   input  wire  [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] result
   output logic        rsp_tuser,   // [0] is_readback
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CntW = $clog2(MAX_TAPS + 1);

   logic [TapCntW-1:0] tap_count_ff, tap_count_in;
   logic [ShiftW-1:0]  acc_shift_ff, acc_shift_in;
   logic               busy_ff, busy_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               readback_ff, readback_in;
   logic [IdxW-1:0]    idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SampleW-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   logic                      req_accept;
   logic                      csr_write;
   logic                      finish;
   logic [KindW-1:0]          req_kind;
   logic [IdxW-1:0]           req_idx;
   logic signed [SampleW-1:0] req_value;
   logic signed [AccW-1:0]    rounded;
   logic signed [AccW-1:0]    shifted;
   cell_ctl_type              ctl;

   logic signed [SampleW-1:0] delay_chain [MAX_TAPS+1];
   logic signed [AccW-1:0]    sum_chain   [MAX_TAPS+1];

   assign req_kind  = req_tuser;
   assign req_idx   = req_tdata[5:0];
   assign req_value = req_tdata[21:6];

   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      tap_count_in = tap_count_ff;
      acc_shift_in = acc_shift_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_TAP_COUNT: tap_count_in = csr_pwdata[TapCntW-1:0];
            REG_ACC_SHIFT: acc_shift_in = csr_pwdata[ShiftW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_TAP_COUNT: csr_prdata = {25'b0, tap_count_ff};
         REG_ACC_SHIFT: csr_prdata = {27'b0, acc_shift_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // broadcast control to the cells
   always_comb begin
      ctl.shift     = req_accept && (req_kind == KIND_SAMPLE);
      ctl.wr_coef   = req_accept && (req_kind == KIND_WR_COEF);
      ctl.wr_delay  = req_accept && (req_kind == KIND_WR_DELAY);
      ctl.readback  = readback_ff;
      ctl.idx       = req_accept ? req_idx : idx_ff;
      ctl.value     = req_value;
      ctl.tap_count = tap_count_ff;
   end

   assign delay_chain[0] = req_value;
   assign sum_chain[0]   = '0;

   for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
      fpfir_cell #(
         .IDX(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .delay_left (delay_chain[i]),
         .sum_left   (sum_chain[i]),
         .delay_out  (delay_chain[i+1]),
         .sum_out    (sum_chain[i+1])
      );
   end

   // half an lsb, then arithmetic shift
   always_comb begin
      rounded = sum_chain[MAX_TAPS];
      if (acc_shift_ff != '0) begin
         rounded = sum_chain[MAX_TAPS] + (AccW'(1) << (acc_shift_ff - ShiftW'(1)));
      end
      shifted = rounded >>> acc_shift_ff;
   end

   assign finish = busy_ff && (cnt_ff == '0) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      readback_in  = readback_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (busy_ff && (cnt_ff != '0)) begin
         cnt_in = cnt_ff - CntW'(1);
      end
      if (finish) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         // a read-back returns the element as stored
         rsp_data_in  = readback_ff ? sum_chain[MAX_TAPS][SampleW-1:0]
                                    : shifted[SampleW-1:0];
         rsp_user_in  = readback_ff;
      end
      if (req_accept) begin
         idx_in = req_idx;
         if ((req_kind == KIND_SAMPLE) || (req_kind == KIND_RD_DELAY)) begin
            busy_in     = 1'b1;
            cnt_in      = CntW'(MAX_TAPS);
            readback_in = (req_kind == KIND_RD_DELAY);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TapCntW'(1);
         acc_shift_ff <= '0;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         readback_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tap_count_ff <= tap_count_in;
         acc_shift_ff <= acc_shift_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         readback_ff  <= readback_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

### verif/fir_response_checker.sv
// fir_response_checker: watches the request, response and csr channels of the fir filter,
// keeps its own copy of the taps and registers, and compares every response transfer
// depends on fpfir_pkg for the item kinds, the register select codes and the field widths
`default_nettype none

module fir_response_checker
   import fpfir_pkg::*;
#(
   parameter int MAX_TAPS = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [23:0] req_tdata,   // [5:0] tap_index, [21:6] value, [23:22] zero
   input  wire  [1:0]  req_tuser,   // [1:0] kind
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [15:0] rsp_tdata,   // [15:0] result
   input  wire         rsp_tuser,   // [0] is_readback
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   input  wire         csr_pready,
   output int          fail_count,
   output int          outstanding
);

   typedef struct packed {
      logic [SampleW-1:0] result;
      logic               is_readback;
   } fir_output_type;

   logic signed [SampleW-1:0] coef_store [MAX_TAPS];
   logic signed [SampleW-1:0] delay_store [MAX_TAPS];
   logic [TapCntW-1:0]        tap_count_cfg;
   logic [ShiftW-1:0]         acc_shift_cfg;
   fir_output_type            expected_outputs [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic int taps_active(input logic [TapCntW-1:0] count);
      if (count == 0) return 1;
      if (count > MAX_TAPS) return MAX_TAPS;
      return int'(count);
   endfunction

   // one filter step: shift the delay line, multiply-accumulate, round and shift
   function automatic logic [SampleW-1:0] filter_sample(input logic signed [SampleW-1:0] sample);
      int                 n;
      logic [AccW-1:0]    acc;
      logic signed [AccW-1:0] prod;
      n   = taps_active(tap_count_cfg);
      acc = '0;
      for (int i = n - 1; i > 0; i--) delay_store[i] = delay_store[i-1];
      delay_store[0] = sample;
      for (int i = 0; i < n; i++) begin
         prod = coef_store[i] * delay_store[i];
         acc  = acc + prod;
      end
      if (acc_shift_cfg != 0) acc = acc + (32'd1 << (acc_shift_cfg - 1));
      acc = $signed(acc) >>> acc_shift_cfg;
      return acc[SampleW-1:0];
   endfunction

   task automatic advance_filter(input logic [KindW-1:0] kind, input logic [IdxW-1:0] idx,
                                 input logic signed [SampleW-1:0] value);
      fir_output_type out;
      case (kind)
         KIND_SAMPLE: begin
            out.result      = filter_sample(value);
            out.is_readback = 1'b0;
            expected_outputs.push_back(out);
         end
         KIND_WR_COEF: begin
            if (idx < MAX_TAPS) coef_store[idx] = value;
         end
         KIND_WR_DELAY: begin
            if (idx < MAX_TAPS) delay_store[idx] = value;
         end
         default: begin
            out.result      = (idx < MAX_TAPS) ? delay_store[idx] : '0;
            out.is_readback = 1'b1;
            expected_outputs.push_back(out);
         end
      endcase
   endtask

   always @(posedge clock) begin
      fir_output_type want;
      if (reset) begin
         tap_count_cfg = 7'd1;
         acc_shift_cfg = '0;
         for (int i = 0; i < MAX_TAPS; i++) begin
            coef_store[i]  = '0;
            delay_store[i] = '0;
         end
         expected_outputs.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outputs.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response transfer: result %h readback %b",
                           rsp_tdata, rsp_tuser);
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_tdata !== want.result || rsp_tuser !== want.is_readback) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("response mismatch: expected result %h readback %b, got %h %b",
                              want.result, want.is_readback, rsp_tdata, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready)
            advance_filter(req_tuser, req_tdata[5:0], req_tdata[21:6]);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_TAP_COUNT) tap_count_cfg = csr_pwdata[TapCntW-1:0];
            else acc_shift_cfg = csr_pwdata[ShiftW-1:0];
         end
      end
      outstanding = expected_outputs.size();
   end

endmodule

`default_nettype wire

### verif/testbench.sv
// testbench: drives requests and csr writes into fixed_point_fir_filter_top with random gaps
// and back-pressure; fir_response_checker predicts and compares, this module gives the verdict
`default_nettype none

module testbench
   import fpfir_pkg::*;
();

   localparam int MAX_TAPS     = 64;
   localparam int SETTLE       = MAX_TAPS + 8;
   localparam int LIMIT_CYCLES = 1500000;
   localparam logic [2:0] TAP_COUNT_ADDR = {REG_TAP_COUNT, 2'b00};
   localparam logic [2:0] ACC_SHIFT_ADDR = {REG_ACC_SHIFT, 2'b00};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          outstanding;
   logic        calm = 1'b0;
   logic [TapCntW-1:0] tap_setting = 7'd1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   fixed_point_fir_filter_top #(.MAX_TAPS(MAX_TAPS)) u_top (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_prdata, .csr_pready
   );

   fir_response_checker #(.MAX_TAPS(MAX_TAPS)) u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .outstanding
   );

   always @(negedge clock) rsp_tready = calm || ($urandom_range(99) >= 26);

   task automatic send_item(input logic [KindW-1:0] kind, input logic [IdxW-1:0] idx,
                            input logic [SampleW-1:0] value);
      while (!calm && $urandom_range(99) < 26) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {2'b00, value, idx};
      do @(posedge clock); while (!req_tready);
   endtask

   // writes leave no trace in the response queue, so allow the pipeline to empty too
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // unused upper bits of the write data carry noise
   task automatic configure(input logic [TapCntW-1:0] taps, input logic [ShiftW-1:0] shift);
      settle();
      csr_write(TAP_COUNT_ADDR, ($urandom() & ~32'h7F) | 32'(taps));
      csr_write(ACC_SHIFT_ADDR, ($urandom() & ~32'h1F) | 32'(shift));
      tap_setting = taps;
   endtask

   function automatic logic [SampleW-1:0] pick_value();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic random_item();
      int r;
      int n;
      r = $urandom_range(99);
      n = (tap_setting == 0) ? 1 : (tap_setting > MAX_TAPS) ? MAX_TAPS : int'(tap_setting);
      if (r < 55)
         send_item(KIND_SAMPLE, 6'($urandom()), pick_value());
      else if (r < 70)
         send_item(KIND_WR_COEF, ($urandom_range(3) != 0) ? 6'($urandom_range(n - 1))
                                                          : 6'($urandom()), pick_value());
      else if (r < 80)
         send_item(KIND_WR_DELAY, 6'($urandom()), pick_value());
      else
         send_item(KIND_RD_DELAY, 6'($urandom()), pick_value());
   endtask

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [TapCntW-1:0] phase_taps [5] = '{7'd64, 7'd0, 7'd127, 7'd64, 7'd1};
      logic [ShiftW-1:0]  phase_shift [5] = '{5'd31, 5'd0, 5'd1, 5'd0, 5'd31};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings first: one tap, no shift, empty store
      repeat (60) random_item();

      configure(7'd4, 5'd15);
      send_item(KIND_WR_COEF, 6'd0, 16'h7FFF);
      send_item(KIND_WR_COEF, 6'd1, 16'h8000);
      send_item(KIND_WR_COEF, 6'd2, 16'hFFFF);
      send_item(KIND_WR_COEF, 6'd3, 16'h0001);
      send_item(KIND_WR_COEF, 6'd63, 16'h8000);
      send_item(KIND_WR_DELAY, 6'd63, 16'h7FFF);
      send_item(KIND_RD_DELAY, 6'd63, 16'h0000);
      send_item(KIND_SAMPLE, 6'd0, 16'h8000);
      send_item(KIND_SAMPLE, 6'd63, 16'h7FFF);
      send_item(KIND_SAMPLE, 6'd21, 16'h8000);
      send_item(KIND_SAMPLE, 6'd42, 16'h0000);
      send_item(KIND_SAMPLE, 6'd0, 16'hFFFF);
      send_item(KIND_RD_DELAY, 6'd0, 16'hFFFF);
      send_item(KIND_RD_DELAY, 6'd3, 16'h0000);
      // elements past the tap count are still addressable
      send_item(KIND_WR_DELAY, 6'd10, 16'h5555);
      send_item(KIND_RD_DELAY, 6'd10, 16'hAAAA);
      send_item(KIND_SAMPLE, 6'd0, 16'h3039);

      for (int p = 0; p < 9; p++) begin
         if (p < 5) configure(phase_taps[p], phase_shift[p]);
         else configure(7'($urandom_range(127)), 5'($urandom()));
         calm = (p == 3);
         repeat (210) random_item();
      end
      calm = 1'b0;

      settle();
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
